FILE: rtl/icph_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icph_pkg - shared types and constants
// Field widths, sum mode codes, protocol numbers and the item handed from the
// accumulator to the fold stage.
// ----------------------------------------------------------------------------
package icph_pkg;

  localparam int unsigned DataW  = 8;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned WordW  = 16;
  localparam int unsigned CountW = 16;

  typedef logic [DataW-1:0]  data_t;
  typedef logic [ModeW-1:0]  mode_code_t;
  typedef logic [WordW-1:0]  word_t;
  typedef logic [CountW-1:0] count_t;

  // Sum mode codes; the unused code behaves like an IP header
  typedef enum logic [ModeW-1:0] {
    MODE_IP  = 2'd0,
    MODE_UDP = 2'd1,
    MODE_TCP = 2'd2
  } mode_t;

  localparam word_t  PROTO_UDP    = 16'd17;
  localparam word_t  PROTO_TCP    = 16'd6;
  localparam count_t PSEUDO_BIAS  = 16'd8;
  localparam word_t  WORD_ONES    = 16'hFFFF;

  // Terms of one finished region, summed and folded downstream
  typedef struct packed {
    word_t sum;
    word_t pad;
    word_t proto;
    word_t len;
  } fin_t;

endpackage

FILE: rtl/icph_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icph_stream_if - byte channel
// One data byte per item with its sum mode and last-byte mark.
// ----------------------------------------------------------------------------
interface icph_stream_if;
  logic                    valid;
  logic                    ready;
  logic [7:0]              data_byte;
  logic [1:0]              sum_mode;
  logic                    last_byte;

  modport source (output valid, output data_byte, output sum_mode, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input sum_mode, input last_byte,
                  output ready);
endinterface

FILE: rtl/icph_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icph_result_if - checksum channel
// One 16-bit checksum per item.
// ----------------------------------------------------------------------------
interface icph_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] checksum;

  modport source (output valid, output checksum, input ready);
  modport sink   (input valid, input checksum, output ready);
endinterface

FILE: rtl/internet_checksum_pseudo_header.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// internet_checksum_pseudo_header - streaming Internet checksum
// Byte-wide one's complement checksum with optional UDP/TCP pseudo-header
// protocol and length terms.
// ----------------------------------------------------------------------------
// Feed the region one byte per item, in buffer order; the first byte of each
// pair is the high byte of a 16-bit word. Mark the final byte with last_byte,
// and give sum_mode on that item: 1 adds protocol 17 (UDP), 2 adds protocol 6
// (TCP), and either adds the byte count minus 8 (modulo 2^16); 0 and the
// unused code add nothing. An odd final byte is padded with a zero low byte.
// Each region gives exactly one checksum item, the complement of the folded
// sum, and the state clears ready for the next region with no gap. The block
// takes one byte every cycle unless a last byte waits for the region terms
// register; the limit on throughput is the 16-bit end-around-carry add in
// the accumulator, done once per byte. The last byte's region terms are
// registered, then the checksum. Three register stages (input, region
// terms, result) decouple the channels: bytes flow while a checksum waits, till they fill.
// ----------------------------------------------------------------------------
module internet_checksum_pseudo_header (
  input  logic          clk,
  input  logic          rst,
  icph_stream_if.sink   stream,
  icph_result_if.source result
);
  import icph_pkg::*;

  // terms of a finished region between the accumulator and the fold stage
  logic fin_valid;
  logic fin_ready;
  fin_t fin;

  // pair bytes, hold the running sum, emit the terms on the last byte
  icph_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .stream    (stream),
    .fin_valid (fin_valid),
    .fin       (fin),
    .fin_ready (fin_ready)
  );

  // add the terms, fold end-around and register the complement
  icph_fold u_fold (
    .clk       (clk),
    .rst       (rst),
    .fin_valid (fin_valid),
    .fin       (fin),
    .fin_ready (fin_ready),
    .result    (result)
  );

endmodule

FILE: rtl/icph_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icph_accum - byte pairing and running sum
// Registers each byte, pairs bytes into big-endian words, keeps a 16-bit
// end-around-carry sum and hands the terms of a finished region onward.
// ----------------------------------------------------------------------------
module icph_accum (
  input  logic            clk,
  input  logic            rst,
  icph_stream_if.sink     stream,
  output logic            fin_valid,
  output icph_pkg::fin_t  fin,
  input  logic            fin_ready
);
  import icph_pkg::*;

  // input register
  logic       iv;
  data_t      ib;
  mode_code_t imode;
  logic       ilast;

  // region state
  data_t  held;
  logic   odd;
  count_t count;
  word_t  sum;

  logic            fin_free;
  logic            in_fire;
  logic            in_free;
  word_t           word;
  logic [WordW:0]  sum_add;
  word_t           sum_new;
  word_t           sum_next;
  data_t           held_next;
  count_t          count_next;
  fin_t            fin_next;
  logic            pseudo;
  word_t           proto;

  assign fin_free = !fin_valid || fin_ready;
  assign in_fire  = iv && (!ilast || fin_free);
  assign in_free  = !iv || in_fire;
  assign stream.ready = in_free;

  always_comb begin
    word       = {held, ib};
    sum_add    = {1'b0, sum} + {1'b0, word};
    sum_new    = sum_add[WordW-1:0] + {{(WordW-1){1'b0}}, sum_add[WordW]};
    sum_next   = odd ? sum_new : sum;
    held_next  = odd ? held : ib;
    count_next = count + count_t'(1);
  end

  always_comb begin
    pseudo = 1'b0;
    proto  = '0;
    unique case (imode)
      MODE_UDP: begin
        pseudo = 1'b1;
        proto  = PROTO_UDP;
      end
      MODE_TCP: begin
        pseudo = 1'b1;
        proto  = PROTO_TCP;
      end
      default: begin
        pseudo = 1'b0;
        proto  = '0;
      end
    endcase
  end

  always_comb begin
    fin_next.sum   = sum_next;
    // an unpaired final byte goes in as a high byte
    fin_next.pad   = odd ? '0 : {ib, {DataW{1'b0}}};
    fin_next.proto = proto;
    fin_next.len   = pseudo ? word_t'(count_next - PSEUDO_BIAS) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_free) begin
      iv <= stream.valid;
    end
    if (in_free) begin
      ib    <= stream.data_byte;
      imode <= stream.sum_mode;
      ilast <= stream.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= '0;
      odd   <= 1'b0;
      count <= '0;
      sum   <= '0;
    end else if (in_fire) begin
      if (ilast) begin
        held  <= '0;
        odd   <= 1'b0;
        count <= '0;
        sum   <= '0;
      end else begin
        held  <= held_next;
        odd   <= !odd;
        count <= count_next;
        sum   <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (fin_free) begin
      fin_valid <= in_fire && ilast;
    end
    if (fin_free) begin
      fin <= fin_next;
    end
  end

  a_odd_tracks_count: assert property (@(posedge clk) disable iff (rst)
    odd == count[0])
    else $error("pairing flag out of step with byte count");

  a_last_makes_fin: assert property (@(posedge clk) disable iff (rst)
    in_fire && ilast |=> fin_valid)
    else $error("last byte did not produce a region result");

  a_fin_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(fin_valid) |-> $past(in_fire && ilast))
    else $error("region result without a last byte");

endmodule

FILE: rtl/icph_fold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icph_fold - final sum, fold and complement
// Adds the terms of a region, folds carries back in twice and registers the
// complemented checksum.
// ----------------------------------------------------------------------------
module icph_fold (
  input  logic            clk,
  input  logic            rst,
  input  logic            fin_valid,
  input  icph_pkg::fin_t  fin,
  output logic            fin_ready,
  icph_result_if.source   result
);
  import icph_pkg::*;

  logic            out_free;
  logic [WordW+1:0] total;
  logic [WordW:0]   fold1;
  word_t            fold2;

  assign out_free  = !result.valid || result.ready;
  assign fin_ready = out_free;

  always_comb begin
    total = {2'b00, fin.sum} + {2'b00, fin.pad} + {2'b00, fin.proto} + {2'b00, fin.len};
    fold1 = {1'b0, total[WordW-1:0]} + {{(WordW-1){1'b0}}, total[WordW+1:WordW]};
    fold2 = fold1[WordW-1:0] + {{(WordW-1){1'b0}}, fold1[WordW]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_free) begin
      result.valid <= fin_valid;
    end
    if (out_free && fin_valid) begin
      result.checksum <= fold2 ^ WORD_ONES;
    end
  end

  a_fin_moves_out: assert property (@(posedge clk) disable iff (rst)
    fin_valid && fin_ready |=> result.valid)
    else $error("accepted region did not reach the output register");

  a_no_spurious_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(fin_valid))
    else $error("checksum shown without a region");

  a_zero_only_if_empty: assert property (@(posedge clk) disable iff (rst)
    fin_valid && (fin.sum != '0) |-> fold2 != '0)
    else $error("fold lost a non-zero sum");

endmodule
